FILE: rtl/core/file_group_membership_table_core_assert.svh
// assertion macros for the file group membership table core
`ifndef FILE_GROUP_MEMBERSHIP_TABLE_CORE_ASSERT_SVH
`define FILE_GROUP_MEMBERSHIP_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FGMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fgmt assertion failed");
`define FGMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fgmt assertion failed");
`else
`define FGMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FGMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/fgmt_pkg.sv
package fgmt_pkg;

  localparam int TABLE_ENTRIES  = 16;
  localparam int GROUP_CAPACITY = 16;

  localparam int ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(GROUP_CAPACITY + 1);
  localparam int SLOTS   = TABLE_ENTRIES * GROUP_CAPACITY;
  localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int KEY_W      = 64;
  localparam int NODE_W     = 8;
  localparam int PORT_W     = 16;
  localparam int IP_W       = 32;
  localparam int EIDX_OUT_W = 4;
  localparam int STATUS_W   = 3;
  localparam int NCOUNT_W   = 5;

  typedef logic [ENTRY_W-1:0]    entry_idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [EIDX_OUT_W-1:0] eidx_out_t;
  typedef logic [NCOUNT_W-1:0]   ncount_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [PORT_W-1:0] port;
    logic [IP_W-1:0]   ip;
  } member_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MEMBER   = 3'd0,
    ST_JOINED   = 3'd1,
    ST_NEW      = 3'd2,
    ST_NOSHARE  = 3'd3,
    ST_TBL_FULL = 3'd4,
    ST_GRP_FULL = 3'd5
  } join_status_t;

  // member slot address: entry * capacity + slot
  function automatic addr_t member_addr(entry_idx_t e, cnt_t j);
    return addr_t'(e) * addr_t'(GROUP_CAPACITY) + addr_t'(j);
  endfunction

endpackage

FILE: rtl/core/fgmt_if.sv
interface fgmt_req_if;
  logic                           valid;
  logic                           ready;
  logic                           share;
  logic [fgmt_pkg::KEY_W-1:0]     file_key;
  logic [fgmt_pkg::NODE_W-1:0]    node;
  logic [fgmt_pkg::PORT_W-1:0]    client_port;
  logic [fgmt_pkg::IP_W-1:0]      node_ip;

  modport source (output valid, share, file_key, node, client_port, node_ip, input ready);
  modport sink   (input valid, share, file_key, node, client_port, node_ip, output ready);
endinterface

interface fgmt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [fgmt_pkg::EIDX_OUT_W-1:0]   entry_index;
  logic [fgmt_pkg::STATUS_W-1:0]     join_status;
  logic                              neighbor_valid;
  logic [fgmt_pkg::NODE_W-1:0]       neighbor_node;
  logic [fgmt_pkg::PORT_W-1:0]       peer_port;
  logic [fgmt_pkg::IP_W-1:0]         peer_ip;
  logic [fgmt_pkg::NCOUNT_W-1:0]     neighbor_count;
  logic                              last;

  modport source (output valid, entry_index, join_status, neighbor_valid, neighbor_node,
                  peer_port, peer_ip, neighbor_count, last, input ready);
  modport sink   (input valid, entry_index, join_status, neighbor_valid, neighbor_node,
                  peer_port, peer_ip, neighbor_count, last, output ready);
endinterface

FILE: rtl/core/fgmt_ram.sv
module fgmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/file_group_membership_table_core.sv
// file group membership table: one request in, one transfer per group member out (one empty transfer if none)
// sequence: accept, key scan (one 64-bit compare per entry, stopping at a hit),
//   a read and compare per member checked on a join, an update, then a read per result
// one request at a time, the next taken only back in idle; output stalls hold the results
// member store is a single-port-read ram; its registered read sets the per-member wait state
// reset: clears occupancy, member counts, sequencer and output valid; no clearing pass
`include "file_group_membership_table_core_assert.svh"

module file_group_membership_table_core (
  input  logic        clk,
  input  logic        rst_n,
  fgmt_req_if.sink    in_req,
  fgmt_rsp_if.source  out_rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHK_WAIT,
    S_CHK_CMP,
    S_UPDATE,
    S_EM_WAIT,
    S_EM_OUT
  } state_t;

  state_t                          state_r;

  logic                            share_r;
  logic [fgmt_pkg::KEY_W-1:0]      key_r;
  logic [fgmt_pkg::NODE_W-1:0]     node_r;
  logic [fgmt_pkg::PORT_W-1:0]     port_r;
  logic [fgmt_pkg::IP_W-1:0]       ip_r;

  fgmt_pkg::entry_idx_t            scan_idx_r;
  logic                            found_r;
  fgmt_pkg::entry_idx_t            hit_r;
  logic                            free_found_r;
  fgmt_pkg::entry_idx_t            free_r;
  fgmt_pkg::cnt_t                  cnt_r;
  fgmt_pkg::cnt_t                  j_r;
  logic                            member_hit_r;

  fgmt_pkg::join_status_t          status_r;
  fgmt_pkg::entry_idx_t            sel_r;
  fgmt_pkg::cnt_t                  em_cnt_r;
  fgmt_pkg::cnt_t                  k_r;
  fgmt_pkg::addr_t                 rd_addr_r;

  logic [fgmt_pkg::TABLE_ENTRIES-1:0] entry_used_r;
  logic [fgmt_pkg::KEY_W-1:0]      entry_key_r    [fgmt_pkg::TABLE_ENTRIES];
  fgmt_pkg::cnt_t                  member_count_r [fgmt_pkg::TABLE_ENTRIES];

  logic                            out_valid_r;
  fgmt_pkg::eidx_out_t             out_index_r;
  fgmt_pkg::join_status_t          out_status_r;
  logic                            out_nvalid_r;
  logic [fgmt_pkg::NODE_W-1:0]     out_node_r;
  logic [fgmt_pkg::PORT_W-1:0]     out_port_r;
  logic [fgmt_pkg::IP_W-1:0]       out_ip_r;
  fgmt_pkg::ncount_t               out_count_r;
  logic                            out_last_r;

  fgmt_pkg::member_t               ram_rdata;
  fgmt_pkg::member_t               ram_wdata;
  logic                            ram_we;

  logic                            scan_hit;
  logic                            scan_last;
  logic                            out_load;
  logic                            em_last;

  logic                            upd_we;
  fgmt_pkg::addr_t                 upd_addr;
  fgmt_pkg::join_status_t          upd_status;
  fgmt_pkg::entry_idx_t            upd_sel;
  fgmt_pkg::cnt_t                  upd_cnt;

  fgmt_ram #(
    .WIDTH ($bits(fgmt_pkg::member_t)),
    .DEPTH (fgmt_pkg::SLOTS)
  ) u_member_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (upd_addr),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign scan_hit  = entry_used_r[scan_idx_r] && (entry_key_r[scan_idx_r] == key_r);
  assign scan_last = (scan_idx_r == fgmt_pkg::entry_idx_t'(fgmt_pkg::TABLE_ENTRIES - 1));
  assign out_load  = (state_r == S_EM_OUT) && (!out_valid_r || out_rsp.ready);
  assign em_last   = (em_cnt_r == '0) || ((k_r + fgmt_pkg::cnt_t'(1)) == em_cnt_r);

  assign ram_wdata.node = node_r;
  assign ram_wdata.port = port_r;
  assign ram_wdata.ip   = ip_r;
  assign ram_we         = (state_r == S_UPDATE) && upd_we;

  // join decision after scan and member check
  always_comb begin
    upd_we     = 1'b0;
    upd_addr   = fgmt_pkg::member_addr(hit_r, cnt_r);
    upd_status = fgmt_pkg::ST_NOSHARE;
    upd_sel    = found_r ? hit_r : '0;
    upd_cnt    = found_r ? cnt_r : member_count_r[0];
    if (share_r) begin
      if (found_r) begin
        if (member_hit_r) begin
          upd_status = fgmt_pkg::ST_MEMBER;
        end else if (cnt_r >= fgmt_pkg::cnt_t'(fgmt_pkg::GROUP_CAPACITY)) begin
          upd_status = fgmt_pkg::ST_GRP_FULL;
        end else begin
          upd_we     = 1'b1;
          upd_status = fgmt_pkg::ST_JOINED;
          upd_cnt    = cnt_r + fgmt_pkg::cnt_t'(1);
        end
      end else if (free_found_r) begin
        upd_we     = 1'b1;
        upd_addr   = fgmt_pkg::member_addr(free_r, '0);
        upd_status = fgmt_pkg::ST_NEW;
        upd_sel    = free_r;
        upd_cnt    = fgmt_pkg::cnt_t'(1);
      end else begin
        upd_status = fgmt_pkg::ST_TBL_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      entry_used_r   <= '0;
      member_count_r <= '{default: '0};
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            share_r      <= in_req.share;
            key_r        <= in_req.file_key;
            node_r       <= in_req.node;
            port_r       <= in_req.client_port;
            ip_r         <= in_req.node_ip;
            scan_idx_r   <= '0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            member_hit_r <= 1'b0;
            cnt_r        <= '0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!entry_used_r[scan_idx_r] && !free_found_r) begin
            free_found_r <= 1'b1;
            free_r       <= scan_idx_r;
          end
          if (scan_hit) begin
            found_r   <= 1'b1;
            hit_r     <= scan_idx_r;
            cnt_r     <= member_count_r[scan_idx_r];
            j_r       <= '0;
            rd_addr_r <= fgmt_pkg::member_addr(scan_idx_r, '0);
            if (share_r && (member_count_r[scan_idx_r] != '0)) begin
              state_r <= S_CHK_WAIT;
            end else begin
              state_r <= S_UPDATE;
            end
          end else if (scan_last) begin
            state_r <= S_UPDATE;
          end else begin
            scan_idx_r <= scan_idx_r + fgmt_pkg::entry_idx_t'(1);
          end
        end
        S_CHK_WAIT: begin
          state_r <= S_CHK_CMP;
        end
        S_CHK_CMP: begin
          if (ram_rdata.node == node_r) begin
            member_hit_r <= 1'b1;
            state_r      <= S_UPDATE;
          end else if ((j_r + fgmt_pkg::cnt_t'(1)) == cnt_r) begin
            state_r <= S_UPDATE;
          end else begin
            j_r       <= j_r + fgmt_pkg::cnt_t'(1);
            rd_addr_r <= fgmt_pkg::member_addr(hit_r, j_r + fgmt_pkg::cnt_t'(1));
            state_r   <= S_CHK_WAIT;
          end
        end
        S_UPDATE: begin
          if (upd_we) begin
            if (found_r) begin
              member_count_r[hit_r] <= upd_cnt;
            end else begin
              entry_used_r[free_r]   <= 1'b1;
              entry_key_r[free_r]    <= key_r;
              member_count_r[free_r] <= upd_cnt;
            end
          end
          status_r  <= upd_status;
          sel_r     <= upd_sel;
          em_cnt_r  <= upd_cnt;
          k_r       <= '0;
          rd_addr_r <= fgmt_pkg::member_addr(upd_sel, '0);
          state_r   <= S_EM_WAIT;
        end
        S_EM_WAIT: begin
          state_r <= S_EM_OUT;
        end
        S_EM_OUT: begin
          if (out_load) begin
            out_index_r  <= fgmt_pkg::eidx_out_t'(sel_r);
            out_status_r <= status_r;
            out_nvalid_r <= (em_cnt_r != '0);
            out_node_r   <= (em_cnt_r != '0) ? ram_rdata.node : '0;
            out_port_r   <= (em_cnt_r != '0) ? ram_rdata.port : '0;
            out_ip_r     <= (em_cnt_r != '0) ? ram_rdata.ip : '0;
            out_count_r  <= fgmt_pkg::ncount_t'(em_cnt_r);
            out_last_r   <= em_last;
            if (em_last) begin
              state_r <= S_IDLE;
            end else begin
              k_r       <= k_r + fgmt_pkg::cnt_t'(1);
              rd_addr_r <= fgmt_pkg::member_addr(sel_r, k_r + fgmt_pkg::cnt_t'(1));
              state_r   <= S_EM_WAIT;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_req.ready           = (state_r == S_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.entry_index    = out_index_r;
  assign out_rsp.join_status    = out_status_r;
  assign out_rsp.neighbor_valid = out_nvalid_r;
  assign out_rsp.neighbor_node  = out_node_r;
  assign out_rsp.peer_port      = out_port_r;
  assign out_rsp.peer_ip        = out_ip_r;
  assign out_rsp.neighbor_count = out_count_r;
  assign out_rsp.last           = out_last_r;

  `FGMT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_req.valid && in_req.ready, !in_req.ready)
  `FGMT_ASSERT_IMP(a_empty_is_last, clk, rst_n, out_rsp.valid && !out_rsp.neighbor_valid,
    out_rsp.last && (out_rsp.neighbor_count == '0))
  `FGMT_ASSERT_IMP(a_count_in_range, clk, rst_n, out_rsp.valid && out_rsp.neighbor_valid,
    (out_rsp.neighbor_count != '0) &&
    (out_rsp.neighbor_count <= fgmt_pkg::ncount_t'(fgmt_pkg::GROUP_CAPACITY)))
  `FGMT_ASSERT_IMP(a_write_on_share, clk, rst_n, ram_we, (state_r == S_UPDATE) && share_r)

endmodule
